@@ rtl/sndag_pkg.sv @@
// Shared types and constants for the strided N-dimensional copy address generator.
// No dependencies; imported by sndag_cell and the top level.
package sndag_pkg;

	// Default geometry, handed down through the top-level parameters
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_ADDR_BITS  = 32;

	// Fixed widths of the register file and the result ports
	localparam int CFG_BITS      = 64;
	localparam int CFG_IDX_BITS  = 3;
	localparam int NUM_DIMS_BITS = 3;
	localparam int BASE_BITS     = 32;
	localparam int OUT_BITS      = 32;

	// Register reset values
	localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RST = NUM_DIMS_BITS'(1);
	localparam logic [CFG_BITS-1:0]      EXTENTS_RST  = 64'h0001_0001_0001_0001;

	// Register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NUM_DIMS,
		REG_BOX_EXTENTS,
		REG_SOURCE_ORIGIN,
		REG_DEST_ORIGIN,
		REG_SOURCE_PITCHES,
		REG_DEST_PITCHES,
		REG_SOURCE_BASE,
		REG_DEST_BASE
	} cfg_reg_t;

	// What an item does as it walks the cell row
	typedef enum logic [1:0] {
		OP_START,  // load origins, accumulate origin * pitch
		OP_STEP,   // ripple an increment with carries
		OP_HOLD    // box already done: pass the pair through unchanged
	} op_t;

	// Control that travels with an item from cell to cell
	typedef struct packed {
		logic valid;
		op_t  op;
		logic carry_s;  // increment into this dimension, source side
		logic carry_d;  // increment into this dimension, destination side
		logic last;     // all source coordinates so far sit on their last value
	} tok_ctl_t;

endpackage

@@ rtl/sndag_cell.sv @@
// One dimension of the address walk: source and destination coordinates of that
// dimension, its offset products, and one register stage toward the next cell. Uses sndag_pkg.
module sndag_cell #(
	parameter int IDX        = 0,
	parameter int MAX_DIMS   = sndag_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS = sndag_pkg::DEF_COORD_BITS,
	parameter int ADDR_BITS  = sndag_pkg::DEF_ADDR_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [$clog2(MAX_DIMS+1)-1:0]         nd,
	input  logic [COORD_BITS-1:0]                 extent,
	input  logic [COORD_BITS-1:0]                 s_org,
	input  logic [COORD_BITS-1:0]                 d_org,
	input  logic [COORD_BITS-1:0]                 s_pitch,
	input  logic [COORD_BITS-1:0]                 d_pitch,
	input  sndag_pkg::tok_ctl_t                   ctl_in,
	input  logic [ADDR_BITS-1:0]                  s_off_in,
	input  logic [ADDR_BITS-1:0]                  d_off_in,
	output sndag_pkg::tok_ctl_t                   ctl_out,
	output logic [ADDR_BITS-1:0]                  s_off_out,
	output logic [ADDR_BITS-1:0]                  d_off_out
);
	import sndag_pkg::*;

	localparam int DW = $clog2(MAX_DIMS+1);
	localparam int PW = 2*COORD_BITS + 1;

	logic                  active, is_top;
	logic [COORD_BITS:0]   ext_full;
	logic [COORD_BITS-1:0] s_pit_eff, d_pit_eff;
	logic [COORD_BITS-1:0] s_end, d_end, s_endm1;
	logic [PW-1:0]         s_wp, d_wp, s_sp, d_sp;
	logic [ADDR_BITS-1:0]  s_wprod_q, d_wprod_q, s_sprod_q, d_sprod_q;
	logic [COORD_BITS-1:0] s_coord_q, d_coord_q, s_coord_d, d_coord_d;
	logic [COORD_BITS-1:0] s_nxt, d_nxt;
	logic                  s_wrap, d_wrap;
	tok_ctl_t              ctl_d, ctl_q;
	logic [ADDR_BITS-1:0]  s_off_d, d_off_d, s_off_q, d_off_q;

	// Place of this cell among the dimensions in use
	assign active = DW'(IDX) < nd;
	assign is_top = DW'(IDX + 1) == nd;

	// Extent of zero counts as 2^COORD_BITS; dimension 0 has unit stride
	assign ext_full  = {(extent == '0), extent};
	assign s_pit_eff = (IDX == 0) ? COORD_BITS'(1) : s_pitch;
	assign d_pit_eff = (IDX == 0) ? COORD_BITS'(1) : d_pitch;
	assign s_end     = s_org + extent;
	assign d_end     = d_org + extent;
	assign s_endm1   = s_end - COORD_BITS'(1);

	// Products from static configuration, registered
	assign s_wp = ext_full * s_pit_eff;
	assign d_wp = ext_full * d_pit_eff;
	assign s_sp = s_org * s_pit_eff;
	assign d_sp = d_org * d_pit_eff;

	always_ff @(posedge clk) begin
		s_wprod_q <= ADDR_BITS'(s_wp);
		d_wprod_q <= ADDR_BITS'(d_wp);
		s_sprod_q <= ADDR_BITS'(s_sp);
		d_sprod_q <= ADDR_BITS'(d_sp);
	end

	// Coordinate update and offset contribution of this dimension
	always_comb begin
		s_nxt     = s_coord_q + COORD_BITS'(1);
		d_nxt     = d_coord_q + COORD_BITS'(1);
		s_coord_d = s_coord_q;
		d_coord_d = d_coord_q;
		s_off_d   = s_off_in;
		d_off_d   = d_off_in;
		s_wrap    = 1'b0;
		d_wrap    = 1'b0;
		ctl_d     = ctl_in;
		if (ctl_in.valid) begin
			unique case (ctl_in.op)
				OP_START: begin
					s_coord_d = s_org;
					d_coord_d = d_org;
					if (active) begin
						s_off_d = s_off_in + s_sprod_q;
						d_off_d = d_off_in + d_sprod_q;
					end
				end
				OP_STEP: begin
					if (active && ctl_in.carry_s) begin
						s_wrap    = !is_top && (s_nxt == s_end);
						s_coord_d = s_wrap ? s_org : s_nxt;
						s_off_d   = s_off_in + ADDR_BITS'(s_pit_eff)
							- (s_wrap ? s_wprod_q : '0);
					end
					if (active && ctl_in.carry_d) begin
						d_wrap    = !is_top && (d_nxt == d_end);
						d_coord_d = d_wrap ? d_org : d_nxt;
						d_off_d   = d_off_in + ADDR_BITS'(d_pit_eff)
							- (d_wrap ? d_wprod_q : '0);
					end
				end
				default: ;  // hold: nothing moves
			endcase
		end
		ctl_d.carry_s = s_wrap;
		ctl_d.carry_d = d_wrap;
		// last-element test runs on source coordinates only
		if (ctl_in.valid && active && (ctl_in.op == OP_START || ctl_in.op == OP_STEP))
			ctl_d.last = ctl_in.last && (s_coord_d == s_endm1);
	end

	// Coordinate and token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_coord_q <= '0;
			d_coord_q <= '0;
			ctl_q     <= '0;
		end else begin
			s_coord_q <= s_coord_d;
			d_coord_q <= d_coord_d;
			ctl_q     <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		s_off_q <= s_off_d;
		d_off_q <= d_off_d;
	end

	assign ctl_out   = ctl_q;
	assign s_off_out = s_off_q;
	assign d_off_out = d_off_q;

endmodule

@@ rtl/strided_nd_copy_address_generator.sv @@
// Strided N-dimensional copy address generator: register file, item entry, a row
// of MAX_DIMS sndag_cell stages and the result buffer. Uses sndag_pkg and sndag_cell.
// Path: an accepted item passes the entry register, the register of each cell and then the
// output register. One item is in the cell row at a time; the carry walks one cell per cycle,
// and the input stalls until the result is loaded into the output register. A finished result
// may wait in the output register while the next item walks.
// Reset: registers take their reset values, no copy in progress (an advance gives the bases).
module strided_nd_copy_address_generator #(
	parameter int MAX_DIMS   = sndag_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS = sndag_pkg::DEF_COORD_BITS,
	parameter int ADDR_BITS  = sndag_pkg::DEF_ADDR_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sndag_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [sndag_pkg::CFG_BITS-1:0]     cfg_data,
	// input items
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               restart,
	// result items
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sndag_pkg::OUT_BITS-1:0]     source_address,
	output logic [sndag_pkg::OUT_BITS-1:0]     dest_address,
	output logic                               last_element
);
	import sndag_pkg::*;

	localparam int DW = $clog2(MAX_DIMS+1);

	// configuration registers
	logic [NUM_DIMS_BITS-1:0] num_dims_q;
	logic [CFG_BITS-1:0]      box_extents_q, source_origin_q, dest_origin_q;
	logic [CFG_BITS-1:0]      source_pitches_q, dest_pitches_q;
	logic [BASE_BITS-1:0]     source_base_q, dest_base_q;
	logic [DW-1:0]            nd_eff;

	// walk state
	logic                     finished_q, busy_q;
	logic [ADDR_BITS-1:0]     s_off_q, d_off_q;
	logic                     accept;
	op_t                      ent_op;
	tok_ctl_t                 ent_ctl_q;
	logic [ADDR_BITS-1:0]     ent_s_off_q, ent_d_off_q;

	// cell row
	tok_ctl_t                 ctl_c [MAX_DIMS+1];
	logic [ADDR_BITS-1:0]     s_off_c [MAX_DIMS+1];
	logic [ADDR_BITS-1:0]     d_off_c [MAX_DIMS+1];
	logic [MAX_DIMS:0]        tok_v;
	logic [COORD_BITS-1:0]    ext_f [MAX_DIMS];
	logic [COORD_BITS-1:0]    so_f [MAX_DIMS];
	logic [COORD_BITS-1:0]    do_f [MAX_DIMS];
	logic [COORD_BITS-1:0]    sp_f [MAX_DIMS];
	logic [COORD_BITS-1:0]    dp_f [MAX_DIMS];
	tok_ctl_t                 tail;

	// result path
	logic [OUT_BITS-1:0]      res_src, res_dst;
	logic                     out_free, out_load;
	logic                     out_valid_q, pend_v_q;
	logic [OUT_BITS-1:0]      out_src_q, out_dst_q, pend_src_q, pend_dst_q;
	logic                     out_last_q, pend_last_q;

	// Configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q       <= NUM_DIMS_RST;
			box_extents_q    <= EXTENTS_RST;
			source_origin_q  <= '0;
			dest_origin_q    <= '0;
			source_pitches_q <= '0;
			dest_pitches_q   <= '0;
			source_base_q    <= '0;
			dest_base_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_DIMS:       num_dims_q       <= cfg_data[NUM_DIMS_BITS-1:0];
				REG_BOX_EXTENTS:    box_extents_q    <= cfg_data;
				REG_SOURCE_ORIGIN:  source_origin_q  <= cfg_data;
				REG_DEST_ORIGIN:    dest_origin_q    <= cfg_data;
				REG_SOURCE_PITCHES: source_pitches_q <= cfg_data;
				REG_DEST_PITCHES:   dest_pitches_q   <= cfg_data;
				REG_SOURCE_BASE:    source_base_q    <= cfg_data[BASE_BITS-1:0];
				REG_DEST_BASE:      dest_base_q      <= cfg_data[BASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Dimensions in use: zero reads as one, saturate at MAX_DIMS
	always_comb begin
		if (num_dims_q == '0)
			nd_eff = DW'(1);
		else if (int'(num_dims_q) > MAX_DIMS)
			nd_eff = DW'(MAX_DIMS);
		else
			nd_eff = DW'(num_dims_q);
	end

	// Unpack per-dimension fields; fields past the register read as zero
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_field
		localparam int SH = g * COORD_BITS;
		if (SH < CFG_BITS) begin : g_in
			assign ext_f[g] = COORD_BITS'(box_extents_q >> SH);
			assign so_f[g]  = COORD_BITS'(source_origin_q >> SH);
			assign do_f[g]  = COORD_BITS'(dest_origin_q >> SH);
			assign sp_f[g]  = COORD_BITS'(source_pitches_q >> SH);
			assign dp_f[g]  = COORD_BITS'(dest_pitches_q >> SH);
		end else begin : g_out
			assign ext_f[g] = '0;
			assign so_f[g]  = '0;
			assign do_f[g]  = '0;
			assign sp_f[g]  = '0;
			assign dp_f[g]  = '0;
		end
	end

	// Item entry
	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (restart)
			ent_op = OP_START;
		else if (finished_q)
			ent_op = OP_HOLD;
		else
			ent_op = OP_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_ctl_q <= '0;
		end else begin
			ent_ctl_q.valid   <= accept;
			ent_ctl_q.op      <= ent_op;
			ent_ctl_q.carry_s <= ent_op == OP_STEP;
			ent_ctl_q.carry_d <= ent_op == OP_STEP;
			ent_ctl_q.last    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s_off_q <= (ent_op == OP_START) ? '0 : s_off_q;
		ent_d_off_q <= (ent_op == OP_START) ? '0 : d_off_q;
	end

	assign ctl_c[0]   = ent_ctl_q;
	assign s_off_c[0] = ent_s_off_q;
	assign d_off_c[0] = ent_d_off_q;

	// Row of dimension cells, dimension 0 first
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
		sndag_cell #(
			.IDX        (g),
			.MAX_DIMS   (MAX_DIMS),
			.COORD_BITS (COORD_BITS),
			.ADDR_BITS  (ADDR_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.nd        (nd_eff),
			.extent    (ext_f[g]),
			.s_org     (so_f[g]),
			.d_org     (do_f[g]),
			.s_pitch   (sp_f[g]),
			.d_pitch   (dp_f[g]),
			.ctl_in    (ctl_c[g]),
			.s_off_in  (s_off_c[g]),
			.d_off_in  (d_off_c[g]),
			.ctl_out   (ctl_c[g+1]),
			.s_off_out (s_off_c[g+1]),
			.d_off_out (d_off_c[g+1])
		);
	end

	for (genvar g = 0; g <= MAX_DIMS; g++) begin : g_tokv
		assign tok_v[g] = ctl_c[g].valid;
	end

	assign tail = ctl_c[MAX_DIMS];

	// Addresses of the finished item
	assign res_src = OUT_BITS'(ADDR_BITS'(source_base_q) + s_off_c[MAX_DIMS]);
	assign res_dst = OUT_BITS'(ADDR_BITS'(dest_base_q) + d_off_c[MAX_DIMS]);

	// Output register with one pending slot behind it
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (pend_v_q || tail.valid) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			finished_q  <= 1'b1;
			s_off_q     <= '0;
			d_off_q     <= '0;
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (out_load)
				busy_q <= 1'b0;
			if (tail.valid) begin
				finished_q <= tail.last;
				s_off_q    <= s_off_c[MAX_DIMS];
				d_off_q    <= d_off_c[MAX_DIMS];
			end
			out_valid_q <= out_load || (out_valid_q && out_stall);
			pend_v_q    <= pend_v_q ? !out_free : (tail.valid && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_src_q  <= pend_v_q ? pend_src_q : res_src;
			out_dst_q  <= pend_v_q ? pend_dst_q : res_dst;
			out_last_q <= pend_v_q ? pend_last_q : tail.last;
		end
		if (tail.valid && !out_free) begin
			pend_src_q  <= res_src;
			pend_dst_q  <= res_dst;
			pend_last_q <= tail.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign source_address = out_src_q;
	assign dest_address   = out_dst_q;
	assign last_element   = out_last_q;

	// At most one item in the cell row or the pending slot
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({tok_v, pend_v_q}) <= 1)
		else $error("more than one item in flight");

	// A finished box repeats its pair flagged as last
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.valid && tail.op == OP_HOLD) |-> tail.last)
		else $error("held pair lost its last flag");

	// The pending slot is used only behind an occupied output register
	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_valid_q)
		else $error("pending result with empty output register");

	// Input is stalled whenever an item is still in the row
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_v) |-> in_stall)
		else $error("input open while an item is walking");

endmodule

@@ test/tb_strided_nd_copy_address_generator.sv @@
`timescale 1ns / 100ps
// Self-checking bench for strided_nd_copy_address_generator: directed table, then random box walks,
// checked against a behavioral address predictor or fixed expected pairs. Needs sndag_pkg and the RTL.
module tb_strided_nd_copy_address_generator;
	import sndag_pkg::*;

	localparam int DIMS        = DEF_MAX_DIMS;
	localparam int CW          = DEF_COORD_BITS;
	localparam int RAND_ITEMS  = 1050;
	localparam int SETTLE_PAD  = DEF_MAX_DIMS + 4;
	localparam int HOLD_CYCLES = 250;
	localparam int IDLE_LIMIT  = 3000;

	// One address pair as the block hands it out
	typedef struct packed {
		logic [OUT_BITS-1:0] src;
		logic [OUT_BITS-1:0] dst;
		logic                last;
	} pair_t;

	// One row of the directed table: a register write or an item
	typedef struct {
		bit       is_cfg;
		cfg_reg_t k;
		logic [CFG_BITS-1:0] v;
		bit       rst;
		bit       known;
		pair_t    want;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    restart;
	logic                    out_valid;
	logic                    out_stall;
	logic [OUT_BITS-1:0]     source_address;
	logic [OUT_BITS-1:0]     dest_address;
	logic                    last_element;

	strided_nd_copy_address_generator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.source_address (source_address),
		.dest_address   (dest_address),
		.last_element   (last_element)
	);

	// Predictor copy of the registers; index 0 is the source side, 1 the destination
	logic [NUM_DIMS_BITS-1:0] nd_reg;
	logic [CFG_BITS-1:0]      ext_reg;
	logic [CFG_BITS-1:0]      org_reg [2];
	logic [CFG_BITS-1:0]      pit_reg [2];
	logic [BASE_BITS-1:0]     base_reg [2];

	// Predictor walk state
	logic [CW-1:0]       pos [2][DIMS];
	logic [OUT_BITS-1:0] off [2];
	bit                  done;

	pair_t pending_pairs [$];
	int    bad_pairs;
	int    n_in;
	int    idle_cycles;
	int    hold_left;
	bit    hold_done;
	bit    steady;

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic [CW-1:0] field(input logic [CFG_BITS-1:0] r, input int i);
		return r[i*CW +: CW];
	endfunction

	function automatic int dims_in_use();
		if (nd_reg == 0)
			return 1;
		if (nd_reg > DIMS)
			return DIMS;
		return int'(nd_reg);
	endfunction

	// zero extent counts as a full wrap of the coordinate
	function automatic logic [CW:0] span(input int i);
		logic [CW-1:0] e;
		e = field(ext_reg, i);
		return (e == 0) ? {1'b1, {CW{1'b0}}} : {1'b0, e};
	endfunction

	function automatic logic [CW-1:0] stride(input int s, input int i);
		return (i == 0) ? CW'(1) : field(pit_reg[s], i);
	endfunction

	function automatic logic [CW-1:0] stop(input int s, input int i);
		return CW'(field(org_reg[s], i) + span(i));
	endfunction

	task automatic set_reg(input cfg_reg_t k, input logic [CFG_BITS-1:0] v);
		case (k)
			REG_NUM_DIMS:       nd_reg = v[NUM_DIMS_BITS-1:0];
			REG_BOX_EXTENTS:    ext_reg = v;
			REG_SOURCE_ORIGIN:  org_reg[0] = v;
			REG_DEST_ORIGIN:    org_reg[1] = v;
			REG_SOURCE_PITCHES: pit_reg[0] = v;
			REG_DEST_PITCHES:   pit_reg[1] = v;
			REG_SOURCE_BASE:    base_reg[0] = v[BASE_BITS-1:0];
			REG_DEST_BASE:      base_reg[1] = v[BASE_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic load_origin(input int s);
		logic [OUT_BITS-1:0] o;
		o = '0;
		for (int i = 0; i < DIMS; i++)
			pos[s][i] = field(org_reg[s], i);
		for (int i = 0; i < dims_in_use(); i++)
			o = o + OUT_BITS'(field(org_reg[s], i)) * OUT_BITS'(stride(s, i));
		off[s] = o;
	endtask

	// Increment dimension 0 and ripple carries up to the top dimension in use
	task automatic step_element(input int s);
		int j;
		logic [OUT_BITS-1:0] o;
		j = 0;
		o = off[s] + 1;
		pos[s][0] = pos[s][0] + CW'(1);
		while (j + 1 < dims_in_use() && pos[s][j] == stop(s, j)) begin
			pos[s][j] = field(org_reg[s], j);
			j++;
			pos[s][j] = pos[s][j] + CW'(1);
			o = o + OUT_BITS'(stride(s, j)) - OUT_BITS'(span(j - 1)) * OUT_BITS'(stride(s, j - 1));
		end
		off[s] = o;
	endtask

	// Last element is judged on the source coordinates only
	function automatic bit on_last_element();
		for (int i = 0; i < dims_in_use(); i++)
			if (pos[0][i] != CW'(stop(0, i) - CW'(1)))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic next_pair(input bit r, output pair_t p);
		if (r) begin
			load_origin(0);
			load_origin(1);
			done = on_last_element();
		end else if (!done) begin
			step_element(0);
			step_element(1);
			done = on_last_element();
		end
		p.src  = base_reg[0] + off[0];
		p.dst  = base_reg[1] + off[1];
		p.last = done;
	endtask

	// Element count of the current box, clamped so huge boxes stay cheap to size
	function automatic int box_len();
		longint n;
		n = 1;
		for (int i = 0; i < dims_in_use(); i++) begin
			n = n * longint'(span(i));
			if (n > 1000)
				n = 1000;
		end
		return int'(n);
	endfunction

	// ---------------- drivers ----------------

	task automatic write_reg(input cfg_reg_t k, input logic [CFG_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= k;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		set_reg(k, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_item(input bit r, input bit known, input pair_t want);
		pair_t p;
		int gap;
		in_valid <= 1'b1;
		restart  <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		next_pair(r, p);
		pending_pairs.push_back(known ? want : p);
		n_in++;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 36)
				gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Block idle: every pair back, then wait out the settle pad for anything in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_PAD) @(posedge clk);
	endtask

	// Random register contents: mostly small boxes, some extreme extents and wrapping origins
	task automatic reshape(input bit all);
		logic [CFG_BITS-1:0] v;
		cfg_reg_t k;
		for (int i = 0; i < 8; i++) begin
			k = cfg_reg_t'(i);
			if (all || $urandom_range(3) == 0) begin
				v = {$urandom, $urandom};
				if (k == REG_NUM_DIMS) begin
					v[NUM_DIMS_BITS-1:0] = NUM_DIMS_BITS'($urandom_range(0, 7));
				end else if (k == REG_BOX_EXTENTS) begin
					for (int d = 0; d < DIMS; d++)
						case ($urandom_range(29))
							0:       v[d*CW +: CW] = '1;
							1:       v[d*CW +: CW] = '0;
							default: v[d*CW +: CW] = CW'($urandom_range(1, 4));
						endcase
				end else if (k == REG_SOURCE_ORIGIN || k == REG_DEST_ORIGIN) begin
					for (int d = 0; d < DIMS; d++)
						case ($urandom_range(3))
							0:       v[d*CW +: CW] = CW'($urandom_range(0, 3));
							1:       v[d*CW +: CW] = CW'($urandom_range(16'hFFFC, 16'hFFFF));
							default: ;
						endcase
				end
				write_reg(k, v);
			end
		end
	endtask

	function automatic plan_row_t cfg_row(input cfg_reg_t k, input logic [CFG_BITS-1:0] v);
		plan_row_t row;
		row = '{is_cfg: 1'b1, k: k, v: v, rst: 1'b0, known: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t item_row(input bit r);
		plan_row_t row;
		row = '{is_cfg: 1'b0, k: REG_NUM_DIMS, v: '0, rst: r, known: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t known_row(input bit r, input logic [31:0] s,
			input logic [31:0] d, input bit l);
		plan_row_t row;
		row = '{is_cfg: 1'b0, k: REG_NUM_DIMS, v: '0, rst: r, known: 1'b1, want: '{s, d, l}};
		return row;
	endfunction

	// ---------------- receiver side ----------------

	// Random stall, plus one long hold-off once traffic is going so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_in >= 300) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= steady ? 1'b0 : ($urandom_range(99) < 36);
		end
	end

	// Compare each accepted pair with the oldest expectation
	always @(posedge clk) begin
		pair_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pairs.size() == 0) begin
				if (bad_pairs < 10)
					$display("unexpected pair: src %h dst %h last %b",
						source_address, dest_address, last_element);
				bad_pairs++;
			end else begin
				w = pending_pairs.pop_front();
				if (w.src !== source_address || w.dst !== dest_address
						|| w.last !== last_element) begin
					if (bad_pairs < 10)
						$display("pair mismatch: src %h/%h dst %h/%h last %b/%b (exp/got)",
							w.src, source_address, w.dst, dest_address, w.last, last_element);
					bad_pairs++;
				end
			end
		end
	end

	// Watchdog: cycles without any handshake completing
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------

	initial begin
		plan_row_t plan [$];
		int n_rand;
		int phase;
		int budget;
		int steps;
		int size;

		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		restart     = 1'b0;
		out_stall   = 1'b0;
		bad_pairs   = 0;
		n_in        = 0;
		idle_cycles = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		steady      = 1'b0;

		// reset view of the block
		nd_reg      = NUM_DIMS_RST;
		ext_reg     = EXTENTS_RST;
		org_reg[0]  = '0;
		org_reg[1]  = '0;
		pit_reg[0]  = '0;
		pit_reg[1]  = '0;
		base_reg[0] = '0;
		base_reg[1] = '0;
		for (int i = 0; i < DIMS; i++) begin
			pos[0][i] = '0;
			pos[1][i] = '0;
		end
		off[0] = '0;
		off[1] = '0;
		done   = 1'b1;

		// advance straight out of reset gives the bases, flagged last
		plan.push_back(known_row(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1));
		plan.push_back(known_row(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1));
		plan.push_back(cfg_row(REG_SOURCE_BASE, 64'hDEAD_BEEF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_DEST_BASE, 64'h0000_0000_8000_0000));
		plan.push_back(known_row(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
		// zero dimensions act as one; source address wraps past the top
		plan.push_back(cfg_row(REG_NUM_DIMS, 64'd0));
		plan.push_back(cfg_row(REG_BOX_EXTENTS, 64'h0001_0001_0001_0003));
		plan.push_back(known_row(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0));
		plan.push_back(known_row(1'b0, 32'h0000_0000, 32'h8000_0001, 1'b0));
		plan.push_back(known_row(1'b0, 32'h0000_0001, 32'h8000_0002, 1'b1));
		plan.push_back(known_row(1'b0, 32'h0000_0001, 32'h8000_0002, 1'b1));
		// too many dimensions saturate; zero extent on top; origins wrap at the coordinate width
		plan.push_back(cfg_row(REG_NUM_DIMS, 64'd7));
		plan.push_back(cfg_row(REG_BOX_EXTENTS, 64'h0000_0002_0001_0002));
		plan.push_back(cfg_row(REG_SOURCE_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_DEST_ORIGIN, 64'h0001_0002_0003_0004));
		plan.push_back(cfg_row(REG_SOURCE_PITCHES, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_DEST_PITCHES, 64'h1000_0100_0010_ABCD));
		plan.push_back(item_row(1'b1));
		for (int i = 0; i < 6; i++)
			plan.push_back(item_row(1'b0));
		// registers change under a copy in progress: coordinates carry on
		plan.push_back(cfg_row(REG_NUM_DIMS, 64'd2));
		for (int i = 0; i < 3; i++)
			plan.push_back(item_row(1'b0));
		// widest extents
		plan.push_back(cfg_row(REG_BOX_EXTENTS, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(cfg_row(REG_NUM_DIMS, 64'd1));
		plan.push_back(item_row(1'b1));
		plan.push_back(item_row(1'b0));
		plan.push_back(item_row(1'b0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].k, plan[i].v);
			end else begin
				push_item(plan[i].rst, plan[i].known, plan[i].want);
			end
		end

		// random phases: new registers, then mostly complete box walks
		n_rand = 0;
		phase  = 0;
		while (n_rand < RAND_ITEMS) begin
			settle();
			steady = (phase == 3 || phase == 4);
			reshape(phase == 0);
			// sometimes keep advancing the old walk under the new registers
			if (phase != 0 && $urandom_range(3) == 0)
				repeat ($urandom_range(1, 5)) begin
					push_item(1'b0, 1'b0, '0);
					n_rand++;
				end
			budget = n_rand + $urandom_range(40, 120);
			while (n_rand < budget && n_rand < RAND_ITEMS) begin
				size  = box_len();
				steps = (size <= 200) ? size - 1 : $urandom_range(3, 40);
				if ($urandom_range(99) < 15)
					steps = $urandom_range(0, steps);
				push_item(1'b1, 1'b0, '0);
				n_rand++;
				repeat (steps) begin
					push_item($urandom_range(99) < 3, 1'b0, '0);
					n_rand++;
				end
				repeat ($urandom_range(0, 2)) begin
					push_item(1'b0, 1'b0, '0);
					n_rand++;
				end
			end
			phase++;
		end

		settle();
		repeat (20) @(posedge clk);
		if (bad_pairs == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
